### rtl/ttcg_pkg.sv
// Shared types and constants for the terminal cursor grid.
// No dependencies; every other file of the block but the checker imports this package.
package ttcg_pkg;

  localparam int unsigned MaxRows = 32;
  localparam int unsigned MaxCols = 128;
  localparam int unsigned TabStep = 4;

  localparam int unsigned RowW    = $clog2(MaxRows);
  localparam int unsigned ColW    = $clog2(MaxCols);
  localparam int unsigned AddrW   = RowW + ColW;
  localparam int unsigned ColCntW = $clog2(MaxCols + 1);
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = $clog2(QDepth);

  localparam int unsigned CharW   = 21;
  localparam int unsigned ColourW = 4;
  localparam int unsigned FlagW   = 4;
  localparam int unsigned LinesW  = 2;

  localparam logic [CharW-1:0] ChNul   = 21'd0;
  localparam logic [CharW-1:0] ChBell  = 21'd7;
  localparam logic [CharW-1:0] ChBs    = 21'd8;
  localparam logic [CharW-1:0] ChTab   = 21'd9;
  localparam logic [CharW-1:0] ChLf    = 21'd10;
  localparam logic [CharW-1:0] ChCr    = 21'd13;
  localparam logic [CharW-1:0] ChSo    = 21'd14;
  localparam logic [CharW-1:0] ChSi    = 21'd15;
  localparam logic [CharW-1:0] ChSpace = 21'h20;

  localparam logic [LinesW-1:0] LinesNone = 2'd0;
  localparam logic [LinesW-1:0] LinesOn   = 2'd1;
  localparam logic [LinesW-1:0] LinesOff  = 2'd2;

  localparam logic [ColourW-1:0] ResetFg = 4'd7;
  localparam logic [ColourW-1:0] ResetBg = 4'd0;

  typedef enum logic [2:0] {
    CFG_ROWS   = 3'd0,
    CFG_COLS   = 3'd1,
    CFG_TOP    = 3'd2,
    CFG_BOTTOM = 3'd3,
    CFG_LDRAW  = 3'd4,
    CFG_BFG    = 3'd5,
    CFG_BBG    = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    K_READ, K_BS, K_LF, K_CR, K_TAB, K_SO, K_SI, K_PRINT
  } kind_e;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_COPY, S_BLANK, S_FINISH
  } back_state_e;

  typedef struct packed {
    logic [CharW-1:0]   ch;
    logic [ColourW-1:0] fg;
    logic [ColourW-1:0] bg;
    logic [FlagW-1:0]   flags;
    logic [LinesW-1:0]  lines;
  } cell_t;

  typedef struct packed {
    kind_e            kind;
    logic             store;
    cell_t            cdata;
    logic             rd_ok;
    logic [AddrW-1:0] rd_addr;
  } cmd_t;

  typedef struct packed {
    logic [5:0]         rows;
    logic [7:0]         cols;
    logic [4:0]         top;
    logic [4:0]         bottom;
    logic               ldraw;
    logic [ColourW-1:0] bfg;
    logic [ColourW-1:0] bbg;
  } cfg_t;

endpackage

### rtl/ttcg_fifo.sv
// Short command queue between the front and back parts.
// Depends on ttcg_pkg for the command type and depth.
module ttcg_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  ttcg_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output ttcg_pkg::cmd_t pop_cmd_o
);
  import ttcg_pkg::*;

  cmd_t                 mem_q [QDepth];
  logic [QPtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]       count_q, count_d;
  logic                 push, pop;

  assign push_ready_o = (count_q != (QPtrW+1)'(QDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### rtl/ttcg_front.sv
// Front part: accepts input items and classifies them into commands.
// Depends on ttcg_pkg for codes and the command type.
module ttcg_front (
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [ttcg_pkg::CharW-1:0]    char_code_i,
  input  logic [ttcg_pkg::ColourW-1:0]  attr_fg_i,
  input  logic [ttcg_pkg::ColourW-1:0]  attr_bg_i,
  input  logic [ttcg_pkg::FlagW-1:0]    attr_flags_i,
  input  logic [4:0]                    read_row_i,
  input  logic [6:0]                    read_col_i,
  input  logic                          clearing_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output ttcg_pkg::cmd_t                push_cmd_o
);
  import ttcg_pkg::*;

  cmd_t cmd;

  always_comb begin
    cmd             = '0;
    cmd.cdata.ch    = char_code_i;
    cmd.cdata.fg    = attr_fg_i;
    cmd.cdata.bg    = attr_bg_i;
    cmd.cdata.flags = attr_flags_i;
    cmd.cdata.lines = LinesNone;
    cmd.rd_ok       = (int'(read_row_i) < MaxRows) && (int'(read_col_i) < MaxCols);
    cmd.rd_addr     = {RowW'(read_row_i), ColW'(read_col_i)};
    cmd.store       = (char_code_i != ChBell) && (char_code_i != ChNul);
    if (op_i) begin
      cmd.kind = K_READ;
    end else begin
      unique case (char_code_i)
        ChBs:    cmd.kind = K_BS;
        ChLf:    cmd.kind = K_LF;
        ChCr:    cmd.kind = K_CR;
        ChTab:   cmd.kind = K_TAB;
        ChSo:    cmd.kind = K_SO;
        ChSi:    cmd.kind = K_SI;
        default: cmd.kind = K_PRINT;
      endcase
    end
  end

  // hold off new items while the grid is being cleared
  assign in_ready_o   = push_ready_i & ~clearing_i;
  assign push_valid_o = in_valid_i & ~clearing_i;
  assign push_cmd_o   = cmd;

endmodule

### rtl/ttcg_back.sv
// Back part: cursor state, cell grid memory, scrolling sequencer, result register.
// Depends on ttcg_pkg for types, codes and grid dimensions.
module ttcg_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ttcg_pkg::cfg_t                cfg_i,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  ttcg_pkg::cmd_t                cmd_i,
  output logic                          clearing_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [4:0]                    pos_row_o,
  output logic [7:0]                    cursor_col_o,
  output logic [ttcg_pkg::CharW-1:0]    cell_char_o,
  output logic [ttcg_pkg::ColourW-1:0]  cell_fg_o,
  output logic [ttcg_pkg::ColourW-1:0]  cell_bg_o,
  output logic [ttcg_pkg::FlagW-1:0]    cell_flags_o,
  output logic [ttcg_pkg::LinesW-1:0]   cell_lines_o
);
  import ttcg_pkg::*;

  cell_t               grid_q [MaxRows*MaxCols];
  cell_t               rdata_q;
  logic                rd_en;
  logic [AddrW-1:0]    rd_addr;

  back_state_e         state_q, state_d;
  logic [AddrW-1:0]    addr_q, addr_d;
  logic [RowW-1:0]     cur_row_q, cur_row_d;
  logic [ColCntW-1:0]  cur_col_q, cur_col_d;
  logic [LinesW-1:0]   lm_q, lm_d;
  logic                pend_store_q, pend_store_d;
  cell_t               pend_cell_q, pend_cell_d;
  logic                rd_ok_q, rd_ok_d;

  logic                wr_pend_q, wr_pend_d;
  logic [AddrW-1:0]    wr_addr_q, wr_addr_d;
  logic                wr_use_rd_q, wr_use_rd_d;
  cell_t               wr_cell_q, wr_cell_d;

  logic                out_valid_q, out_load, out_free;
  logic [RowW-1:0]     out_row_q, out_row_d;
  logic [ColCntW-1:0]  out_col_q, out_col_d;
  cell_t               out_cell_q, out_cell_d;

  logic [RowW:0]       rows_eff;
  logic [ColCntW-1:0]  cols_eff;
  logic [RowW-1:0]     rows_m1, bottom, top, row_s, nr_row, row_b;
  logic [ColCntW-1:0]  col_s, col_b;
  logic [ColCntW:0]    tab_col;
  logic                nr_scroll, wrap;
  cell_t               blank_cell, reset_cell, put_cell;

  always_comb begin
    if (cfg_i.rows == '0) begin
      rows_eff = (RowW+1)'(1);
    end else if (int'(cfg_i.rows) > MaxRows) begin
      rows_eff = (RowW+1)'(MaxRows);
    end else begin
      rows_eff = (RowW+1)'(cfg_i.rows);
    end
    if (cfg_i.cols == '0) begin
      cols_eff = ColCntW'(1);
    end else if (int'(cfg_i.cols) > MaxCols) begin
      cols_eff = ColCntW'(MaxCols);
    end else begin
      cols_eff = ColCntW'(cfg_i.cols);
    end
    rows_m1 = RowW'(rows_eff - 1'b1);
    bottom  = (RowW'(cfg_i.bottom) < rows_m1) ? RowW'(cfg_i.bottom) : rows_m1;
    top     = (RowW'(cfg_i.top) < bottom) ? RowW'(cfg_i.top) : bottom;
    row_s   = (cur_row_q > rows_m1) ? rows_m1 : cur_row_q;
    col_s   = (cur_col_q > cols_eff) ? cols_eff : cur_col_q;
    // line feed from the saturated row
    nr_scroll = 1'b0;
    if (row_s > bottom) begin
      nr_row = (row_s >= rows_m1) ? rows_m1 : row_s + 1'b1;
    end else if (row_s < bottom) begin
      nr_row = row_s + 1'b1;
    end else begin
      nr_row    = bottom;
      nr_scroll = 1'b1;
    end
    wrap    = (col_s >= cols_eff);
    row_b   = wrap ? nr_row : row_s;
    col_b   = wrap ? '0 : col_s;
    tab_col = (ColCntW+1)'(col_s) + (ColCntW+1)'(TabStep)
            - (ColCntW+1)'(col_s % TabStep);
  end

  always_comb begin
    blank_cell       = '0;
    blank_cell.ch    = ChSpace;
    blank_cell.fg    = cfg_i.bfg;
    blank_cell.bg    = cfg_i.bbg;
    reset_cell       = '0;
    reset_cell.ch    = ChSpace;
    reset_cell.fg    = ResetFg;
    reset_cell.bg    = ResetBg;
    put_cell         = cmd_i.cdata;
    put_cell.lines   = lm_q;
  end

  assign out_free    = ~out_valid_q | out_ready_i;
  assign clearing_o  = (state_q == S_CLEAR);

  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    cur_row_d    = cur_row_q;
    cur_col_d    = cur_col_q;
    lm_d         = lm_q;
    pend_store_d = pend_store_q;
    pend_cell_d  = pend_cell_q;
    rd_ok_d      = rd_ok_q;
    wr_pend_d    = 1'b0;
    wr_addr_d    = wr_addr_q;
    wr_use_rd_d  = 1'b0;
    wr_cell_d    = wr_cell_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    cmd_ready_o  = 1'b0;
    out_load     = 1'b0;
    out_row_d    = out_row_q;
    out_col_d    = out_col_q;
    out_cell_d   = '0;

    unique case (state_q)
      S_CLEAR: begin
        wr_pend_d = 1'b1;
        wr_addr_d = addr_q;
        wr_cell_d = reset_cell;
        addr_d    = addr_q + 1'b1;
        if (addr_q == '1) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        // wait for the last write to land so a read sees it
        cmd_ready_o = ~wr_pend_q & out_free;
        if (cmd_valid_i && cmd_ready_o) begin
          cur_row_d = row_s;
          cur_col_d = col_s;
          out_load  = 1'b1;
          unique case (cmd_i.kind)
            K_READ: begin
              rd_en    = 1'b1;
              rd_addr  = cmd_i.rd_addr;
              rd_ok_d  = cmd_i.rd_ok;
              out_load = 1'b0;
              state_d  = S_READ;
            end
            K_BS: begin
              cur_col_d = (col_s != '0) ? col_s - 1'b1 : '0;
            end
            K_CR: begin
              cur_col_d = '0;
            end
            K_TAB: begin
              cur_col_d = (tab_col >= (ColCntW+1)'(cols_eff)) ? cols_eff - 1'b1
                                                              : ColCntW'(tab_col);
            end
            K_SO: begin
              lm_d = cfg_i.ldraw ? LinesOn : LinesNone;
            end
            K_SI: begin
              lm_d = cfg_i.ldraw ? LinesOff : LinesNone;
            end
            K_LF: begin
              cur_row_d = nr_row;
              if (nr_scroll) begin
                out_load     = 1'b0;
                pend_store_d = 1'b0;
              end
            end
            K_PRINT: begin
              cur_row_d = row_b;
              cur_col_d = col_b;
              if (wrap && nr_scroll) begin
                out_load     = 1'b0;
                pend_store_d = cmd_i.store;
                pend_cell_d  = put_cell;
              end else if (cmd_i.store) begin
                wr_pend_d = 1'b1;
                wr_addr_d = {row_b, ColW'(col_b)};
                wr_cell_d = put_cell;
                cur_col_d = col_b + 1'b1;
              end
            end
            default: ;
          endcase
          // scroll needed: move rows top+1..bottom up, then blank bottom
          if ((cmd_i.kind == K_LF && nr_scroll) ||
              (cmd_i.kind == K_PRINT && wrap && nr_scroll)) begin
            if (top == bottom) begin
              addr_d  = {bottom, ColW'(0)};
              state_d = S_BLANK;
            end else begin
              addr_d  = {top, ColW'(0)};
              state_d = S_COPY;
            end
          end
          out_row_d = cur_row_d;
          out_col_d = cur_col_d;
        end
      end

      S_READ: begin
        out_load   = 1'b1;
        out_row_d  = cur_row_q;
        out_col_d  = cur_col_q;
        out_cell_d = rd_ok_q ? rdata_q : '0;
        state_d    = S_IDLE;
      end

      S_COPY: begin
        rd_en       = 1'b1;
        rd_addr     = addr_q + AddrW'(MaxCols);
        wr_pend_d   = 1'b1;
        wr_addr_d   = addr_q;
        wr_use_rd_d = 1'b1;
        addr_d      = addr_q + 1'b1;
        if (addr_q[ColW-1:0] == '1 && addr_q[AddrW-1:ColW] == bottom - 1'b1) begin
          state_d = S_BLANK;
        end
      end

      S_BLANK: begin
        wr_pend_d = 1'b1;
        wr_addr_d = addr_q;
        wr_cell_d = blank_cell;
        addr_d    = addr_q + 1'b1;
        if (addr_q[ColW-1:0] == '1) begin
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        out_load  = 1'b1;
        if (pend_store_q) begin
          wr_pend_d = 1'b1;
          wr_addr_d = {cur_row_q, ColW'(cur_col_q)};
          wr_cell_d = pend_cell_q;
          cur_col_d = cur_col_q + 1'b1;
        end
        out_row_d = cur_row_q;
        out_col_d = cur_col_d;
        state_d   = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      addr_q       <= '0;
      cur_row_q    <= '0;
      cur_col_q    <= '0;
      lm_q         <= LinesNone;
      pend_store_q <= 1'b0;
      rd_ok_q      <= 1'b0;
      wr_pend_q    <= 1'b0;
      wr_use_rd_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      addr_q       <= addr_d;
      cur_row_q    <= cur_row_d;
      cur_col_q    <= cur_col_d;
      lm_q         <= lm_d;
      pend_store_q <= pend_store_d;
      rd_ok_q      <= rd_ok_d;
      wr_pend_q    <= wr_pend_d;
      wr_use_rd_q  <= wr_use_rd_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_cell_q <= pend_cell_d;
    wr_addr_q   <= wr_addr_d;
    wr_cell_q   <= wr_cell_d;
    if (out_load) begin
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      out_cell_q <= out_cell_d;
    end
  end

  // grid memory: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (wr_pend_q) begin
      grid_q[wr_addr_q] <= wr_use_rd_q ? rdata_q : wr_cell_q;
    end
    if (rd_en) begin
      rdata_q <= grid_q[rd_addr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pos_row_o    = 5'(out_row_q);
  assign cursor_col_o = 8'(out_col_q);
  assign cell_char_o  = out_cell_q.ch;
  assign cell_fg_o    = out_cell_q.fg;
  assign cell_bg_o    = out_cell_q.bg;
  assign cell_flags_o = out_cell_q.flags;
  assign cell_lines_o = out_cell_q.lines;

endmodule

### rtl/text_terminal_cursor_grid.sv
// Top level of the character-cell terminal grid: configuration registers,
// front classifier, command queue and back executor. Depends on ttcg_pkg.
//
// After reset the block clears all 4096 grid cells, one a cycle, and takes no
// item until the clear is done; configuration writes are taken throughout.
// Cursor moves, shift-out/in, bell, NUL and line feeds that do not scroll are
// taken back to back while the result is not stalled. A stored character's
// write is registered and lands after its command, and the single write port
// makes the next command wait for it. A cell read goes through the registered
// memory read and the S_READ state. A line feed at the bottom of the scroll
// region, or a character whose pending wrap lands there, moves the rows below
// the region's top up one and blanks the bottom row, all on the one memory.
module text_terminal_cursor_grid (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [7:0]                    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [ttcg_pkg::CharW-1:0]    char_code_i,
  input  logic [ttcg_pkg::ColourW-1:0]  attr_fg_i,
  input  logic [ttcg_pkg::ColourW-1:0]  attr_bg_i,
  input  logic [ttcg_pkg::FlagW-1:0]    attr_flags_i,
  input  logic [4:0]                    read_row_i,
  input  logic [6:0]                    read_col_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [4:0]                    pos_row_o,
  output logic [7:0]                    cursor_col_o,
  output logic [ttcg_pkg::CharW-1:0]    cell_char_o,
  output logic [ttcg_pkg::ColourW-1:0]  cell_fg_o,
  output logic [ttcg_pkg::ColourW-1:0]  cell_bg_o,
  output logic [ttcg_pkg::FlagW-1:0]    cell_flags_o,
  output logic [ttcg_pkg::LinesW-1:0]   cell_lines_o
);
  import ttcg_pkg::*;

  cfg_t cfg_q;
  logic clearing, push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows   <= 6'd24;
      cfg_q.cols   <= 8'd80;
      cfg_q.top    <= 5'd0;
      cfg_q.bottom <= 5'd23;
      cfg_q.ldraw  <= 1'b0;
      cfg_q.bfg    <= ResetFg;
      cfg_q.bbg    <= ResetBg;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROWS:   cfg_q.rows   <= cfg_data_i[5:0];
        CFG_COLS:   cfg_q.cols   <= cfg_data_i;
        CFG_TOP:    cfg_q.top    <= cfg_data_i[4:0];
        CFG_BOTTOM: cfg_q.bottom <= cfg_data_i[4:0];
        CFG_LDRAW:  cfg_q.ldraw  <= cfg_data_i[0];
        CFG_BFG:    cfg_q.bfg    <= cfg_data_i[3:0];
        CFG_BBG:    cfg_q.bbg    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  ttcg_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .char_code_i  (char_code_i),
    .attr_fg_i    (attr_fg_i),
    .attr_bg_i    (attr_bg_i),
    .attr_flags_i (attr_flags_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .clearing_i   (clearing),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  ttcg_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  ttcg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_valid_i  (pop_valid),
    .cmd_ready_o  (pop_ready),
    .cmd_i        (pop_cmd),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pos_row_o    (pos_row_o),
    .cursor_col_o (cursor_col_o),
    .cell_char_o  (cell_char_o),
    .cell_fg_o    (cell_fg_o),
    .cell_bg_o    (cell_bg_o),
    .cell_flags_o (cell_flags_o),
    .cell_lines_o (cell_lines_o)
  );

endmodule

### rtl/ttcg_checker.sv
// Port-level checks for the terminal cursor grid, bound to the top level.
// Depends only on the top-level ports.
module ttcg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  cursor_col_o,
  input logic [4:0]  pos_row_o,
  input logic [1:0]  cell_lines_o
);

  // result holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cursor_col_o)
      && $stable(pos_row_o))
    else $error("result changed while stalled");

  // grid clear runs straight after reset
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_o)
    else $error("item taken during grid clear");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cursor_col_o <= 8'd128)
    else $error("cursor column out of range");

  a_lines_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cell_lines_o != 2'd3)
    else $error("bad line drawing code");

endmodule

bind text_terminal_cursor_grid ttcg_checker u_ttcg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .cursor_col_o (cursor_col_o),
  .pos_row_o    (pos_row_o),
  .cell_lines_o (cell_lines_o)
);
